@@ sv/efj_pkg.sv @@
// Shared types and constants for the Euler flux Jacobian block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package efj_pkg;

    localparam int GAMMA_W  = 18;
    localparam logic [GAMMA_W-1:0] GAMMA_RST = 18'd91750;
    localparam int NUM_DIRS = 3;
    localparam int NUM_ROWS = 5;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_HOLD
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_HALF
    } t_alu_op;

    // Micro-steps of the shared arithmetic unit, in dependency order.
    typedef enum logic [5:0] {
        ST_GM1, ST_OMG,
        ST_UU00, ST_UU11, ST_UU22, ST_UU01, ST_UU02, ST_UU12,
        ST_KS1, ST_KSQ, ST_P2, ST_GE, ST_PMG, ST_PHI, ST_GMPHI,
        ST_CW0, ST_CW1, ST_CW2,
        ST_GU0, ST_GU1, ST_GU2,
        ST_OU0, ST_OU1, ST_OU2,
        ST_OUU00, ST_OUU11, ST_OUU22, ST_OUU01, ST_OUU02, ST_OUU12,
        ST_DD0, ST_DD1, ST_DD2,
        ST_DG0, ST_DG1, ST_DG2
    } t_step;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ sv/efj_front.sv @@
// Front end: accepts a state beat, flags bad density and divides the
// momenta and energy by density in four bit-serial lanes. Uses efj_pkg.
`timescale 1ns / 1ps

module efj_front import efj_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [DATA_WIDTH-1:0]       i_density,
    input  logic [DATA_WIDTH-1:0]       i_momentum_x,
    input  logic [DATA_WIDTH-1:0]       i_momentum_y,
    input  logic [DATA_WIDTH-1:0]       i_momentum_z,
    input  logic [DATA_WIDTH-1:0]       i_total_energy,
    input  t_q_stat                     i_q_stat,
    output logic                        o_push,
    output logic [4*(DATA_WIDTH+1):0]   o_push_data
);

    localparam int DW = DATA_WIDTH;
    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    t_front_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_den;
    logic          r_bad;
    logic [3:0]    r_neg;
    logic [NW-1:0] r_num [4];
    logic [DW-1:0] r_rem [4];
    logic [NW-1:0] r_quo [4];

    logic [DW-1:0] lane_in [4];
    logic          take;
    logic          in_bad;

    assign lane_in[0] = i_momentum_x;
    assign lane_in[1] = i_momentum_y;
    assign lane_in[2] = i_momentum_z;
    assign lane_in[3] = i_total_energy;

    assign in_bad = i_density[DW-1] || (i_density == '0);
    assign take   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (take) n_state = in_bad ? FR_HOLD : FR_DIV;
            end
            FR_DIV: begin
                if (r_cnt == CW'(1)) n_state = FR_HOLD;
            end
            FR_HOLD: begin
                if (!i_q_stat.full) begin
                    if (take) n_state = in_bad ? FR_HOLD : FR_DIV;
                    else n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_push     = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            FR_IDLE: begin
                o_in_stall = 1'b0;
            end
            FR_HOLD: begin
                o_push     = !i_q_stat.full;
                o_in_stall = i_q_stat.full;
            end
            default: begin
                o_push     = 1'b0;
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (take) r_cnt <= CW'(NW);
            else if (r_state == FR_DIV) r_cnt <= r_cnt - CW'(1);
        end
    end

    // One quotient bit per lane per cycle, restoring division.
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [DW:0]   rem_sh;
        logic          q_bit;
        logic [DW:0]   rem_sub;
        logic [DW-1:0] mag;

        assign mag     = lane_in[l][DW-1] ? (~lane_in[l] + DW'(1)) : lane_in[l];
        assign rem_sh  = {r_rem[l], r_num[l][NW-1]};
        assign q_bit   = rem_sh >= {1'b0, r_den};
        assign rem_sub = rem_sh - {1'b0, r_den};

        always_ff @(posedge i_clk) begin
            if (take) begin
                r_num[l] <= {mag, {FRAC_BITS{1'b0}}};
                r_neg[l] <= lane_in[l][DW-1];
                r_rem[l] <= '0;
                r_quo[l] <= '0;
            end else if (r_state == FR_DIV) begin
                r_num[l] <= {r_num[l][NW-2:0], 1'b0};
                r_rem[l] <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_quo[l] <= {r_quo[l][NW-2:0], q_bit};
            end
        end

        // Clip the quotient magnitude to the signed range.
        logic [NW-1:0] lim;
        logic [NW-1:0] m;
        logic          clip;
        logic [DW-1:0] val;

        assign lim  = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}} + NW'(r_neg[l]);
        assign clip = r_quo[l] > lim;
        assign m    = clip ? lim : r_quo[l];
        assign val  = r_neg[l] ? (~m[DW-1:0] + DW'(1)) : m[DW-1:0];
        assign o_push_data[l*(DW+1) +: (DW+1)] = {clip, val};
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_den <= i_density;
            r_bad <= in_bad;
        end
    end

    assign o_push_data[4*(DW+1)] = r_bad;

endmodule

@@ sv/efj_fifo.sv @@
// Two-entry queue between the front end and the back end.
// Uses efj_pkg for the status struct.
`timescale 1ns / 1ps

module efj_fifo import efj_pkg::*; #(
    parameter int WIDTH = 133
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            if (i_push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;

endmodule

@@ sv/efj_back.sv @@
// Back end: holds gamma, runs the shared saturating arithmetic unit over the
// intermediate terms, then emits fifteen Jacobian rows. Uses efj_pkg.
`timescale 1ns / 1ps

module efj_back import efj_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [GAMMA_W-1:0]          i_cfg_wr_data,
    input  t_q_stat                     i_q_stat,
    input  logic [4*(DATA_WIDTH+1):0]   i_q_data,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_direction,
    output logic [2:0]                  o_row_index,
    output logic [DATA_WIDTH-1:0]       o_entry_0,
    output logic [DATA_WIDTH-1:0]       o_entry_1,
    output logic [DATA_WIDTH-1:0]       o_entry_2,
    output logic [DATA_WIDTH-1:0]       o_entry_3,
    output logic [DATA_WIDTH-1:0]       o_entry_4,
    output logic                        o_last_of_run,
    output logic                        o_bad_density,
    output logic                        o_saturated
);

    localparam int DW = DATA_WIDTH;
    localparam int UW = DATA_WIDTH + 64;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    // Bit DW is the clip mark, bits DW-1:0 the value.
    typedef logic [DW:0] t_fx;

    localparam t_fx ZERO = '0;

    function automatic t_fx f_add(t_fx a, t_fx b);
        logic [DW:0] sum;
        logic        ovf;
        logic [DW-1:0] v;
        sum = {a[DW-1], a[DW-1:0]} + {b[DW-1], b[DW-1:0]};
        ovf = sum[DW] ^ sum[DW-1];
        v   = ovf ? (sum[DW] ? MINV : MAXV) : sum[DW-1:0];
        return {a[DW] | b[DW] | ovf, v};
    endfunction

    function automatic t_fx f_sub(t_fx a, t_fx b);
        logic [DW:0] dif;
        logic        ovf;
        logic [DW-1:0] v;
        dif = {a[DW-1], a[DW-1:0]} - {b[DW-1], b[DW-1:0]};
        ovf = dif[DW] ^ dif[DW-1];
        v   = ovf ? (dif[DW] ? MINV : MAXV) : dif[DW-1:0];
        return {a[DW] | b[DW] | ovf, v};
    endfunction

    function automatic t_fx f_mul(t_fx a, t_fx b);
        logic            neg;
        logic [DW-1:0]   ma;
        logic [DW-1:0]   mb;
        logic [2*DW-1:0] pr;
        logic [2*DW-1:0] m;
        logic [2*DW-1:0] lim;
        logic            s;
        logic [DW-1:0]   v;
        neg = a[DW-1] ^ b[DW-1];
        ma  = a[DW-1] ? (~a[DW-1:0] + DW'(1)) : a[DW-1:0];
        mb  = b[DW-1] ? (~b[DW-1:0] + DW'(1)) : b[DW-1:0];
        pr  = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
        m   = pr >> FRAC_BITS;
        lim = {{(DW+1){1'b0}}, {(DW-1){1'b1}}} + (2*DW)'(neg);
        s   = a[DW] | b[DW];
        if (m > lim) begin
            m = lim;
            s = 1'b1;
        end
        v = neg ? (~m[DW-1:0] + DW'(1)) : m[DW-1:0];
        return {s, v};
    endfunction

    // Halving truncated toward zero.
    function automatic t_fx f_half(t_fx a);
        logic [DW-1:0] t;
        t = a[DW-1:0] + {{(DW-1){1'b0}}, a[DW-1]};
        return {a[DW], t[DW-1], t[DW-1:1]};
    endfunction

    function automatic t_fx f_sat_u(logic [UW-1:0] m);
        logic [UW-1:0] lim;
        lim = {{(UW-DW+1){1'b0}}, {(DW-1){1'b1}}};
        if (m > lim) return {1'b1, MAXV};
        return {1'b0, m[DW-1:0]};
    endfunction

    // Slot of a symmetric velocity product: squares first, then cross terms.
    function automatic logic [2:0] f_pair(logic [1:0] a, logic [1:0] b);
        if (a == b) return {1'b0, a};
        return 3'(a) + 3'(b) + 3'd2;
    endfunction

    t_back_state r_state, n_state;
    t_step       r_step;
    logic [GAMMA_W-1:0] r_gamma;
    logic [1:0]  r_dir;
    logic [2:0]  r_row;
    logic        r_bad;

    t_fx r_u [3];
    t_fx r_e;
    t_fx r_gm1, r_omg, r_ks, r_ksq, r_p2, r_ge, r_pmg, r_phi, r_gmphi;
    t_fx r_uu  [6];
    t_fx r_ouu [6];
    t_fx r_cw  [3];
    t_fx r_gu  [3];
    t_fx r_ou  [3];
    t_fx r_dd  [3];
    t_fx r_dg  [3];

    logic           r_out_valid;
    logic [1:0]     r_out_dir;
    logic [2:0]     r_out_row;
    logic [DW-1:0]  r_out_ent [5];
    logic           r_out_last;
    logic           r_out_bad;
    logic           r_out_sat;

    t_fx     g_fx, one_fx;
    t_fx     alu_a, alu_b, alu_res;
    t_alu_op alu_op;
    logic    out_free, emit, last_row;
    t_fx     ent [5];
    logic [1:0] kk;

    assign g_fx   = f_sat_u(UW'(r_gamma));
    assign one_fx = f_sat_u(UW'(1) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gamma <= GAMMA_RST;
        else if (i_cfg_wr_en) r_gamma <= i_cfg_wr_data;
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign last_row = (r_dir == 2'(NUM_DIRS-1)) && (r_row == 3'(NUM_ROWS-1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) n_state = i_q_data[4*(DW+1)] ? BK_EMIT : BK_CALC;
            end
            BK_CALC: begin
                if (r_step == ST_DG2) n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free && last_row) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = !i_q_stat.empty;
            BK_EMIT: emit = out_free;
            default: begin
                o_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_step  <= ST_GM1;
            r_dir   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= ST_GM1;
                r_dir  <= '0;
                r_row  <= '0;
            end else begin
                if (r_state == BK_CALC) r_step <= t_step'(r_step + 6'd1);
                if (emit) begin
                    if (r_row == 3'(NUM_ROWS-1)) begin
                        r_row <= '0;
                        r_dir <= r_dir + 2'd1;
                    end else begin
                        r_row <= r_row + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_u[0] <= i_q_data[0*(DW+1) +: (DW+1)];
            r_u[1] <= i_q_data[1*(DW+1) +: (DW+1)];
            r_u[2] <= i_q_data[2*(DW+1) +: (DW+1)];
            r_e    <= i_q_data[3*(DW+1) +: (DW+1)];
            r_bad  <= i_q_data[4*(DW+1)];
        end
    end

    // Operand selection for the shared unit.
    always_comb begin
        alu_a  = ZERO;
        alu_b  = ZERO;
        alu_op = ALU_MUL;
        case (r_step)
            ST_GM1:   begin alu_a = g_fx;     alu_b = one_fx;   alu_op = ALU_SUB; end
            ST_OMG:   begin alu_a = one_fx;   alu_b = g_fx;     alu_op = ALU_SUB; end
            ST_UU00:  begin alu_a = r_u[0];   alu_b = r_u[0];   end
            ST_UU11:  begin alu_a = r_u[1];   alu_b = r_u[1];   end
            ST_UU22:  begin alu_a = r_u[2];   alu_b = r_u[2];   end
            ST_UU01:  begin alu_a = r_u[0];   alu_b = r_u[1];   end
            ST_UU02:  begin alu_a = r_u[0];   alu_b = r_u[2];   end
            ST_UU12:  begin alu_a = r_u[1];   alu_b = r_u[2];   end
            ST_KS1:   begin alu_a = r_uu[0];  alu_b = r_uu[1];  alu_op = ALU_ADD; end
            ST_KSQ:   begin alu_a = r_ks;     alu_b = r_uu[2];  alu_op = ALU_ADD; end
            ST_P2:    begin alu_a = r_gm1;    alu_b = r_ksq;    end
            ST_GE:    begin alu_a = g_fx;     alu_b = r_e;      end
            ST_PMG:   begin alu_a = r_p2;     alu_b = r_ge;     alu_op = ALU_SUB; end
            ST_PHI:   begin alu_a = r_p2;     alu_op = ALU_HALF; end
            ST_GMPHI: begin alu_a = r_ge;     alu_b = r_phi;    alu_op = ALU_SUB; end
            ST_CW0:   begin alu_a = r_u[0];   alu_b = r_pmg;    end
            ST_CW1:   begin alu_a = r_u[1];   alu_b = r_pmg;    end
            ST_CW2:   begin alu_a = r_u[2];   alu_b = r_pmg;    end
            ST_GU0:   begin alu_a = g_fx;     alu_b = r_u[0];   end
            ST_GU1:   begin alu_a = g_fx;     alu_b = r_u[1];   end
            ST_GU2:   begin alu_a = g_fx;     alu_b = r_u[2];   end
            ST_OU0:   begin alu_a = r_omg;    alu_b = r_u[0];   end
            ST_OU1:   begin alu_a = r_omg;    alu_b = r_u[1];   end
            ST_OU2:   begin alu_a = r_omg;    alu_b = r_u[2];   end
            ST_OUU00: begin alu_a = r_omg;    alu_b = r_uu[0];  end
            ST_OUU11: begin alu_a = r_omg;    alu_b = r_uu[1];  end
            ST_OUU22: begin alu_a = r_omg;    alu_b = r_uu[2];  end
            ST_OUU01: begin alu_a = r_omg;    alu_b = r_uu[3];  end
            ST_OUU02: begin alu_a = r_omg;    alu_b = r_uu[4];  end
            ST_OUU12: begin alu_a = r_omg;    alu_b = r_uu[5];  end
            ST_DD0:   begin alu_a = r_u[0];   alu_b = r_u[0];   alu_op = ALU_ADD; end
            ST_DD1:   begin alu_a = r_u[1];   alu_b = r_u[1];   alu_op = ALU_ADD; end
            ST_DD2:   begin alu_a = r_u[2];   alu_b = r_u[2];   alu_op = ALU_ADD; end
            ST_DG0:   begin alu_a = r_dd[0];  alu_b = r_ou[0];  alu_op = ALU_ADD; end
            ST_DG1:   begin alu_a = r_dd[1];  alu_b = r_ou[1];  alu_op = ALU_ADD; end
            ST_DG2:   begin alu_a = r_dd[2];  alu_b = r_ou[2];  alu_op = ALU_ADD; end
            default:  begin alu_a = ZERO;     alu_b = ZERO;     end
        endcase
    end

    always_comb begin
        case (alu_op)
            ALU_ADD:  alu_res = f_add(alu_a, alu_b);
            ALU_SUB:  alu_res = f_sub(alu_a, alu_b);
            ALU_MUL:  alu_res = f_mul(alu_a, alu_b);
            ALU_HALF: alu_res = f_half(alu_a);
            default:  alu_res = ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_CALC) begin
            case (r_step)
                ST_GM1:   r_gm1    <= alu_res;
                ST_OMG:   r_omg    <= alu_res;
                ST_UU00:  r_uu[0]  <= alu_res;
                ST_UU11:  r_uu[1]  <= alu_res;
                ST_UU22:  r_uu[2]  <= alu_res;
                ST_UU01:  r_uu[3]  <= alu_res;
                ST_UU02:  r_uu[4]  <= alu_res;
                ST_UU12:  r_uu[5]  <= alu_res;
                ST_KS1:   r_ks     <= alu_res;
                ST_KSQ:   r_ksq    <= alu_res;
                ST_P2:    r_p2     <= alu_res;
                ST_GE:    r_ge     <= alu_res;
                ST_PMG:   r_pmg    <= alu_res;
                ST_PHI:   r_phi    <= alu_res;
                ST_GMPHI: r_gmphi  <= alu_res;
                ST_CW0:   r_cw[0]  <= alu_res;
                ST_CW1:   r_cw[1]  <= alu_res;
                ST_CW2:   r_cw[2]  <= alu_res;
                ST_GU0:   r_gu[0]  <= alu_res;
                ST_GU1:   r_gu[1]  <= alu_res;
                ST_GU2:   r_gu[2]  <= alu_res;
                ST_OU0:   r_ou[0]  <= alu_res;
                ST_OU1:   r_ou[1]  <= alu_res;
                ST_OU2:   r_ou[2]  <= alu_res;
                ST_OUU00: r_ouu[0] <= alu_res;
                ST_OUU11: r_ouu[1] <= alu_res;
                ST_OUU22: r_ouu[2] <= alu_res;
                ST_OUU01: r_ouu[3] <= alu_res;
                ST_OUU02: r_ouu[4] <= alu_res;
                ST_OUU12: r_ouu[5] <= alu_res;
                ST_DD0:   r_dd[0]  <= alu_res;
                ST_DD1:   r_dd[1]  <= alu_res;
                ST_DD2:   r_dd[2]  <= alu_res;
                ST_DG0:   r_dg[0]  <= alu_res;
                ST_DG1:   r_dg[1]  <= alu_res;
                ST_DG2:   r_dg[2]  <= alu_res;
                default:  r_ks     <= r_ks;
            endcase
        end
    end

    // Row assembly: at most one saturating add or subtract per entry.
    assign kk = 2'(r_row - 3'd1);

    always_comb begin
        for (int j = 0; j < 5; j++) ent[j] = ZERO;
        case (r_row)
            3'd0: begin
                ent[3'(r_dir) + 3'd1] = one_fx;
            end
            3'd1, 3'd2, 3'd3: begin
                ent[0] = f_sub((kk == r_dir) ? r_phi : ZERO, r_uu[f_pair(kk, r_dir)]);
                for (int j = 0; j < 3; j++) begin
                    if (kk == r_dir) begin
                        ent[1 + j] = (2'(j) == r_dir) ? r_dg[r_dir] : r_ou[j];
                    end else if (2'(j) == r_dir) begin
                        ent[1 + j] = r_u[kk];
                    end else if (2'(j) == kk) begin
                        ent[1 + j] = r_u[r_dir];
                    end
                end
                ent[4] = (kk == r_dir) ? r_gm1 : ZERO;
            end
            3'd4: begin
                ent[0] = r_cw[r_dir];
                for (int j = 0; j < 3; j++) begin
                    ent[1 + j] = f_add((2'(j) == r_dir) ? r_gmphi : ZERO,
                                       r_ouu[f_pair(2'(j), r_dir)]);
                end
                ent[4] = r_gu[r_dir];
            end
            default: begin
                for (int j = 0; j < 5; j++) ent[j] = ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_dir  <= r_dir;
            r_out_row  <= r_row;
            r_out_last <= last_row;
            r_out_bad  <= r_bad;
            r_out_sat  <= !r_bad && (ent[0][DW] | ent[1][DW] | ent[2][DW] |
                                     ent[3][DW] | ent[4][DW]);
            for (int j = 0; j < 5; j++) begin
                r_out_ent[j] <= r_bad ? '0 : ent[j][DW-1:0];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_direction   = r_out_dir;
    assign o_row_index   = r_out_row;
    assign o_entry_0     = r_out_ent[0];
    assign o_entry_1     = r_out_ent[1];
    assign o_entry_2     = r_out_ent[2];
    assign o_entry_3     = r_out_ent[3];
    assign o_entry_4     = r_out_ent[4];
    assign o_last_of_run = r_out_last;
    assign o_bad_density = r_out_bad;
    assign o_saturated   = r_out_sat;

`ifndef NO_ASSERTIONS
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |->
            r_out_dir == 2'(NUM_DIRS-1) && r_out_row == 3'(NUM_ROWS-1))
        else $error("last beat flagged on a row other than the final one");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bad |-> !r_out_sat && r_out_ent[0] == '0 &&
            r_out_ent[4] == '0)
        else $error("bad density beat carries data or a clip mark");

    a_hold_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_EMIT && r_out_valid && i_out_stall |=>
            $stable(r_row) && $stable(r_dir))
        else $error("row sequencer advanced under a stalled output");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_CALC |-> !o_pop)
        else $error("queue popped while terms are still being computed");
`endif

endmodule

@@ sv/euler_flux_jacobian_3d.sv @@
// Top level of the three-dimensional Euler flux Jacobian block.
// Depends on efj_pkg, efj_front, efj_fifo and efj_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall | density, momenta, total energy
//   out     | output    | o_out_valid/i_out_stall | direction, row, five entries, flags
//   cfg     | input     | i_cfg_wr_en             | gas gamma, 18 bits
//
// Each state beat yields fifteen row beats. The front end runs the four
// parallel bit-serial divisions; the back end then steps its single shared
// arithmetic unit through the intermediate terms and emits the rows.
// A bad-density item skips the arithmetic in the back end.
// Reset is synchronous and restores gamma to 1.4; an output stall holds the
// row sequencer while the front end keeps dividing into the two-entry queue.
`timescale 1ns / 1ps

module euler_flux_jacobian_3d import efj_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [GAMMA_W-1:0]    i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [DATA_WIDTH-1:0] i_density,
    input  logic [DATA_WIDTH-1:0] i_momentum_x,
    input  logic [DATA_WIDTH-1:0] i_momentum_y,
    input  logic [DATA_WIDTH-1:0] i_momentum_z,
    input  logic [DATA_WIDTH-1:0] i_total_energy,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_direction,
    output logic [2:0]            o_row_index,
    output logic [DATA_WIDTH-1:0] o_entry_0,
    output logic [DATA_WIDTH-1:0] o_entry_1,
    output logic [DATA_WIDTH-1:0] o_entry_2,
    output logic [DATA_WIDTH-1:0] o_entry_3,
    output logic [DATA_WIDTH-1:0] o_entry_4,
    output logic                  o_last_of_run,
    output logic                  o_bad_density,
    output logic                  o_saturated
);

    localparam int QW = 4 * (DATA_WIDTH + 1) + 1;

    logic          push;
    logic          pop;
    logic [QW-1:0] push_data;
    logic [QW-1:0] pop_data;
    t_q_stat       q_stat;

    efj_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_density      (i_density),
        .i_momentum_x   (i_momentum_x),
        .i_momentum_y   (i_momentum_y),
        .i_momentum_z   (i_momentum_z),
        .i_total_energy (i_total_energy),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    efj_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_stat  (q_stat)
    );

    efj_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_stat      (q_stat),
        .i_q_data      (pop_data),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_direction   (o_direction),
        .o_row_index   (o_row_index),
        .o_entry_0     (o_entry_0),
        .o_entry_1     (o_entry_1),
        .o_entry_2     (o_entry_2),
        .o_entry_3     (o_entry_3),
        .o_entry_4     (o_entry_4),
        .o_last_of_run (o_last_of_run),
        .o_bad_density (o_bad_density),
        .o_saturated   (o_saturated)
    );

endmodule
